>>> rtl/scm_pkg.sv
// Shared types and constants of the stack calculator machine.
`default_nettype none
package scm_pkg;
	localparam logic [4:0] CMD_PUSH_CONST = 5'd0;
	localparam logic [4:0] CMD_PUSH_VAR   = 5'd1;
	localparam logic [4:0] CMD_DROP       = 5'd2;
	localparam logic [4:0] CMD_ADD        = 5'd3;
	localparam logic [4:0] CMD_SUB        = 5'd4;
	localparam logic [4:0] CMD_MUL        = 5'd5;
	localparam logic [4:0] CMD_DIV        = 5'd6;
	localparam logic [4:0] CMD_NEG        = 5'd7;
	localparam logic [4:0] CMD_EVAL       = 5'd8;
	localparam logic [4:0] CMD_ASSIGN     = 5'd9;
	localparam logic [4:0] CMD_ADD_ASSIGN = 5'd10;
	localparam logic [4:0] CMD_SUB_ASSIGN = 5'd11;
	localparam logic [4:0] CMD_MUL_ASSIGN = 5'd12;
	localparam logic [4:0] CMD_DIV_ASSIGN = 5'd13;
	localparam logic [4:0] CMD_PRINT      = 5'd14;
	localparam logic [4:0] CMD_PRINT_NONL = 5'd15;
	localparam logic [4:0] CMD_CLEAR      = 5'd16;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_UNDERFLOW = 3'd1;
	localparam logic [2:0] ST_OVERFLOW  = 3'd2;
	localparam logic [2:0] ST_DIV_ZERO  = 3'd3;
	localparam logic [2:0] ST_UNDEFINED = 3'd4;

	localparam logic [63:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] Q_MIN = 64'h8000_0000_0000_0000;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_NEG = 3'd4
	} alu_op_t;

	typedef struct packed {
		logic [4:0]  command;
		logic signed [63:0] operand;
		logic [4:0]  var_index;
	} in_beat_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        print_valid;
		logic        newline;
		logic signed [63:0] result_value;
		logic [6:0]  stack_depth;
	} out_beat_t;

	typedef struct packed {
		logic    load_in;
		logic    rd_top;
		logic    rd_sec;
		logic    rd_var;
		logic    alu_start;
		alu_op_t alu_op;
		logic    alu_var_first;
		logic    wr_stack;
		logic    wr_var;
		logic    finish;
	} dp_cmd_t;

	typedef struct packed {
		logic [4:0] command;
		logic       alu_done;
	} dp_stat_t;

	function automatic logic [63:0] sat_mag(input logic neg, input logic hi_nz,
		input logic [63:0] m);
		logic [63:0] r;
		begin
			if (neg) r = (hi_nz || m > Q_MIN) ? Q_MIN : (64'd0 - m);
			else     r = (hi_nz || m > Q_MAX) ? Q_MAX : m;
			return r;
		end
	endfunction
endpackage
`default_nettype wire

>>> rtl/scm_alu.sv
// Saturating Q32.32 arithmetic unit with serial multiply and divide.
`default_nettype none
module scm_alu (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire scm_pkg::alu_op_t op,
	input  wire logic [63:0]    a,
	input  wire logic [63:0]    b,
	output logic                done,
	output logic [63:0]         res,
	output logic                dz
);
	typedef enum logic [3:0] {
		A_IDLE = 4'b0001,
		A_MUL  = 4'b0010,
		A_DIV  = 4'b0100,
		A_FIN  = 4'b1000
	} alu_state_t;

	alu_state_t  state_q;
	logic [6:0]  cnt_q;
	logic        neg_q;
	logic [63:0] ub_q;
	logic [63:0] ua_q;
	logic [127:0] acc_q;
	logic [127:0] num_q;
	logic [64:0] rem_q;
	logic [127:0] quo_q;
	logic [1:0]  part_q;
	logic [63:0] ma, mb, sum_r, dif_r;
	logic [31:0] pa, pb;
	logic [63:0] pprod;
	logic [64:0] rsh;

	assign ma = a[63] ? (64'd0 - a) : a;
	assign mb = b[63] ? (64'd0 - b) : b;
	assign sum_r = a + b;
	assign dif_r = a - b;
	assign pa = part_q[1] ? ua_q[63:32] : ua_q[31:0];
	assign pb = part_q[0] ? ub_q[63:32] : ub_q[31:0];
	assign pprod = pa * pb;
	assign rsh = {rem_q[63:0], num_q[127]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			done    <= 1'b0;
			cnt_q   <= '0;
			part_q  <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				A_IDLE: begin
					if (start) begin
						dz    <= 1'b0;
						neg_q <= a[63] ^ b[63];
						ua_q  <= ma;
						ub_q  <= mb;
						case (op)
							scm_pkg::OP_ADD: begin
								res <= (a[63] == b[63] && sum_r[63] != a[63]) ?
									(a[63] ? scm_pkg::Q_MIN : scm_pkg::Q_MAX) : sum_r;
								state_q <= A_FIN;
							end
							scm_pkg::OP_SUB: begin
								res <= (a[63] != b[63] && dif_r[63] != a[63]) ?
									(a[63] ? scm_pkg::Q_MIN : scm_pkg::Q_MAX) : dif_r;
								state_q <= A_FIN;
							end
							scm_pkg::OP_NEG: begin
								res <= (a == scm_pkg::Q_MIN) ? scm_pkg::Q_MAX : (64'd0 - a);
								state_q <= A_FIN;
							end
							scm_pkg::OP_MUL: begin
								acc_q   <= '0;
								part_q  <= 2'd0;
								state_q <= A_MUL;
							end
							scm_pkg::OP_DIV: begin
								if (b == 64'd0) begin
									dz <= 1'b1;
									res <= (a == 64'd0) ? 64'd0 :
										(a[63] ? scm_pkg::Q_MIN : scm_pkg::Q_MAX);
									state_q <= A_FIN;
								end else begin
									num_q   <= {32'd0, ma, 32'd0};
									rem_q   <= '0;
									quo_q   <= '0;
									cnt_q   <= 7'd0;
									state_q <= A_DIV;
								end
							end
							default: state_q <= A_FIN;
						endcase
					end
				end
				A_MUL: begin
					case (part_q)
						2'd0: acc_q <= acc_q + {64'd0, pprod};
						2'd1, 2'd2: acc_q <= acc_q + {32'd0, pprod, 32'd0};
						default: acc_q <= acc_q + {pprod, 64'd0};
					endcase
					part_q <= part_q + 2'd1;
					if (part_q == 2'd3) begin
						state_q <= A_FIN;
						cnt_q   <= 7'd1;
					end
				end
				A_DIV: begin
					num_q <= {num_q[126:0], 1'b0};
					if (rsh >= {1'b0, ub_q}) begin
						rem_q <= rsh - {1'b0, ub_q};
						quo_q <= {quo_q[126:0], 1'b1};
					end else begin
						rem_q <= rsh;
						quo_q <= {quo_q[126:0], 1'b0};
					end
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd127) begin
						state_q <= A_FIN;
						cnt_q   <= 7'd2;
					end
				end
				A_FIN: begin
					if (cnt_q == 7'd1)
						res <= scm_pkg::sat_mag(neg_q, |acc_q[127:96], acc_q[95:32]);
					else if (cnt_q == 7'd2)
						res <= scm_pkg::sat_mag(neg_q, |quo_q[127:64], quo_q[63:0]);
					cnt_q   <= '0;
					done    <= 1'b1;
					state_q <= A_IDLE;
				end
				default: state_q <= A_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> rtl/scm_datapath.sv
// Stack memory, variable table, ALU and result register of the calculator.
`default_nettype none
module scm_datapath #(
	parameter int STACK_DEPTH = 64,
	parameter int VAR_COUNT = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire scm_pkg::in_beat_t in_beat,
	input  wire scm_pkg::dp_cmd_t  cmd,
	output scm_pkg::dp_stat_t      stat,
	output scm_pkg::out_beat_t     out_beat
);
	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int VW  = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;

	logic [63:0] stack_mem [STACK_DEPTH];
	logic [63:0] var_mem [VAR_COUNT];
	logic [VAR_COUNT-1:0] def_q;
	logic [SPW-1:0] sp_q;
	scm_pkg::in_beat_t ib_q;
	logic [63:0] top_q, sec_q, var_q;
	logic [VW-1:0] vsel_q;
	logic [2:0]  status_q;
	logic        pv_q, nl_q;
	logic [63:0] pr_q;
	logic        alu_done, alu_dz;
	logic [63:0] alu_res;
	logic [63:0] alu_a, alu_b;
	logic        need1, need2, under, over, is_asg, is_ar;
	logic [SPW-1:0] sp_new;
	logic [SPW-1:0] wr_ptr;
	logic [63:0] wr_data;
	logic [VW-1:0] top_v;

	assign top_v = VW'(top_q % VAR_COUNT);

	always_comb begin
		need1 = ib_q.command == scm_pkg::CMD_DROP || ib_q.command == scm_pkg::CMD_NEG ||
			ib_q.command == scm_pkg::CMD_EVAL || ib_q.command == scm_pkg::CMD_PRINT ||
			ib_q.command == scm_pkg::CMD_PRINT_NONL;
		is_ar = ib_q.command >= scm_pkg::CMD_ADD && ib_q.command <= scm_pkg::CMD_DIV;
		is_asg = ib_q.command >= scm_pkg::CMD_ASSIGN &&
			ib_q.command <= scm_pkg::CMD_DIV_ASSIGN;
		need2 = is_ar || is_asg;
		under = (need1 && sp_q < SPW'(1)) || (need2 && sp_q < SPW'(2));
		over = (ib_q.command == scm_pkg::CMD_PUSH_CONST ||
			ib_q.command == scm_pkg::CMD_PUSH_VAR) && sp_q >= SPW'(STACK_DEPTH);
		alu_a = cmd.alu_var_first ? var_q :
			(cmd.alu_op == scm_pkg::OP_NEG) ? top_q : sec_q;
		alu_b = cmd.alu_var_first ? sec_q : top_q;
		sp_new = sp_q;
		wr_ptr = sp_q - SPW'(1);
		wr_data = alu_res;
		if (!under && !over) begin
			case (ib_q.command)
				scm_pkg::CMD_PUSH_CONST: begin
					sp_new = sp_q + SPW'(1); wr_ptr = sp_q; wr_data = ib_q.operand;
				end
				scm_pkg::CMD_PUSH_VAR: begin
					sp_new = sp_q + SPW'(1); wr_ptr = sp_q;
					wr_data = 64'(ib_q.var_index % VAR_COUNT);
				end
				scm_pkg::CMD_DROP, scm_pkg::CMD_PRINT, scm_pkg::CMD_PRINT_NONL:
					sp_new = sp_q - SPW'(1);
				scm_pkg::CMD_ADD, scm_pkg::CMD_SUB, scm_pkg::CMD_MUL, scm_pkg::CMD_DIV: begin
					sp_new = sp_q - SPW'(1); wr_ptr = sp_q - SPW'(2);
				end
				scm_pkg::CMD_EVAL: wr_data = var_q;
				scm_pkg::CMD_ASSIGN, scm_pkg::CMD_ADD_ASSIGN, scm_pkg::CMD_SUB_ASSIGN,
				scm_pkg::CMD_MUL_ASSIGN, scm_pkg::CMD_DIV_ASSIGN: begin
					sp_new = sp_q - SPW'(1); wr_ptr = sp_q - SPW'(2); wr_data = sec_q;
				end
				scm_pkg::CMD_CLEAR: sp_new = '0;
				default: sp_new = sp_q;
			endcase
		end
	end

	scm_alu u_alu (
		.clk(clk), .arst_n(arst_n), .start(cmd.alu_start), .op(cmd.alu_op),
		.a(alu_a), .b(alu_b), .done(alu_done), .res(alu_res), .dz(alu_dz)
	);

	assign stat.command  = ib_q.command;
	assign stat.alu_done = alu_done;

	always_ff @(posedge clk) begin
		if (cmd.load_in) ib_q <= in_beat;
		if (cmd.rd_top) top_q <= stack_mem[SAW'(sp_q - SPW'(1))];
		if (cmd.rd_sec) sec_q <= stack_mem[SAW'(sp_q - SPW'(2))];
		if (cmd.rd_var) begin
			var_q  <= var_mem[top_v];
			vsel_q <= top_v;
		end
		if (cmd.wr_stack && !under && !over &&
			(ib_q.command <= scm_pkg::CMD_DIV_ASSIGN && ib_q.command != scm_pkg::CMD_DROP))
			stack_mem[SAW'(wr_ptr)] <= wr_data;
		if (cmd.wr_stack && !under && !over)
			pr_q <= top_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q     <= '0;
			def_q    <= '0;
			status_q <= scm_pkg::ST_OK;
			pv_q     <= 1'b0;
			nl_q     <= 1'b0;
			for (int i = 0; i < VAR_COUNT; i++) var_mem[i] <= '0;
		end else if (cmd.wr_stack) begin
			sp_q <= sp_new;
			pv_q <= 1'b0;
			nl_q <= 1'b0;
			if (under) status_q <= scm_pkg::ST_UNDERFLOW;
			else if (over) status_q <= scm_pkg::ST_OVERFLOW;
			else if ((ib_q.command == scm_pkg::CMD_DIV ||
				ib_q.command == scm_pkg::CMD_DIV_ASSIGN) && alu_dz)
				status_q <= scm_pkg::ST_DIV_ZERO;
			else if (ib_q.command == scm_pkg::CMD_EVAL && !def_q[vsel_q])
				status_q <= scm_pkg::ST_UNDEFINED;
			else status_q <= scm_pkg::ST_OK;
			if (!under && !over) begin
				if (is_asg) begin
					var_mem[vsel_q] <= (ib_q.command == scm_pkg::CMD_ASSIGN) ? sec_q : alu_res;
					def_q[vsel_q]   <= 1'b1;
				end
				if (ib_q.command == scm_pkg::CMD_PRINT ||
					ib_q.command == scm_pkg::CMD_PRINT_NONL) begin
					pv_q <= 1'b1;
					nl_q <= ib_q.command == scm_pkg::CMD_PRINT;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_beat.status       <= status_q;
			out_beat.print_valid  <= pv_q;
			out_beat.newline      <= nl_q;
			out_beat.stack_depth  <= 7'(sp_q);
			out_beat.result_value <= pv_q ? pr_q : ((sp_q == '0) ? 64'd0 : top_q);
		end
	end
endmodule
`default_nettype wire

>>> rtl/scm_ctrl.sv
// Instruction sequencer of the stack calculator machine.
`default_nettype none
module scm_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  wire logic              out_stall,
	input  wire scm_pkg::dp_stat_t stat,
	output scm_pkg::dp_cmd_t       cmd
);
	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_RD    = 9'b000000010,
		S_VAR   = 9'b000000100,
		S_START = 9'b000001000,
		S_WAIT  = 9'b000010000,
		S_WB    = 9'b000100000,
		S_TOP   = 9'b001000000,
		S_FIN   = 9'b010000000,
		S_OUT   = 9'b100000000
	} ctrl_state_t;

	ctrl_state_t state_q;
	logic is_ar, is_cmp, uses_alu;

	assign is_ar  = stat.command >= scm_pkg::CMD_ADD && stat.command <= scm_pkg::CMD_DIV;
	assign is_cmp = stat.command >= scm_pkg::CMD_ADD_ASSIGN &&
		stat.command <= scm_pkg::CMD_DIV_ASSIGN;
	assign uses_alu = is_ar || is_cmp || stat.command == scm_pkg::CMD_NEG;

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = state_q == S_OUT;

	always_comb begin
		cmd = '0;
		cmd.alu_op = scm_pkg::OP_ADD;
		case (stat.command)
			scm_pkg::CMD_SUB, scm_pkg::CMD_SUB_ASSIGN: cmd.alu_op = scm_pkg::OP_SUB;
			scm_pkg::CMD_MUL, scm_pkg::CMD_MUL_ASSIGN: cmd.alu_op = scm_pkg::OP_MUL;
			scm_pkg::CMD_DIV, scm_pkg::CMD_DIV_ASSIGN: cmd.alu_op = scm_pkg::OP_DIV;
			scm_pkg::CMD_NEG: cmd.alu_op = scm_pkg::OP_NEG;
			default: cmd.alu_op = scm_pkg::OP_ADD;
		endcase
		cmd.alu_var_first = is_cmp;
		case (state_q)
			S_IDLE:  cmd.load_in = in_valid;
			S_RD:    begin cmd.rd_top = 1'b1; cmd.rd_sec = 1'b1; end
			S_VAR:   cmd.rd_var = 1'b1;
			S_START: cmd.alu_start = uses_alu;
			S_WB:    cmd.wr_stack = 1'b1;
			S_TOP:   cmd.rd_top = 1'b1;
			S_FIN:   cmd.finish = 1'b1;
			default: cmd.load_in = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE:  if (in_valid) state_q <= S_RD;
				S_RD:    state_q <= S_VAR;
				S_VAR:   state_q <= S_START;
				S_START: state_q <= uses_alu ? S_WAIT : S_WB;
				S_WAIT:  if (stat.alu_done) state_q <= S_WB;
				S_WB:    state_q <= S_TOP;
				S_TOP:   state_q <= S_FIN;
				S_FIN:   state_q <= S_OUT;
				S_OUT:   if (!out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> rtl/stack_calculator_machine_top.sv
// Top level of the stack calculator machine.
// One instruction per beat on Q32.32 values; one result beat per instruction.
// An instruction is taken only after the result beat of the one before it is
// taken. The ALU does add, subtract and negate, and a divide by zero, without a
// serial loop. A multiply sums four 32x32 partial products on one multiplier. A
// divide makes one quotient bit per cycle over the 128-bit shifted dividend. The
// stack lives in a memory with registered reads; variables reset to zero.
`default_nettype none
module stack_calculator_machine_top #(
	parameter int STACK_DEPTH = 64,
	parameter int VAR_COUNT = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire scm_pkg::in_beat_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output scm_pkg::out_beat_t      out_data
);
	scm_pkg::dp_cmd_t  cmd;
	scm_pkg::dp_stat_t stat;

	scm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd)
	);

	scm_datapath #(.STACK_DEPTH(STACK_DEPTH), .VAR_COUNT(VAR_COUNT)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_beat(in_data), .cmd(cmd), .stat(stat),
		.out_beat(out_data)
	);
endmodule
`default_nettype wire
